FILE: src/grid_articulation_point_finder_top_defines.svh
// Assertion macros shared by the RTL of the articulation point finder.
`ifndef GRID_ARTICULATION_POINT_FINDER_TOP_DEFINES_SVH
`define GRID_ARTICULATION_POINT_FINDER_TOP_DEFINES_SVH
// Concurrent check on clk, disabled while reset is asserted.
`define GAPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GAPF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

FILE: src/gapf_pkg.sv
// Types and constants shared by the articulation point finder.
package gapf_pkg;
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_TOP,
		ST_NB,
		ST_NBCHK,
		ST_POP,
		ST_POPUPD,
		ST_CLEAR
	} state_t;

	localparam logic [1:0] CODE_IMPOSSIBLE = 2'd0;
	localparam logic [1:0] CODE_CUT = 2'd1;
	localparam logic [1:0] CODE_NONE = 2'd2;

	localparam logic [1:0] DIR_DOWN = 2'd0;
	localparam logic [1:0] DIR_UP = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;
endpackage

FILE: src/grid_articulation_point_finder_top.sv
// Articulation point finder top level: grid loader, stack-based search and result register.
// Cells arrive one per accepted request in raster order, one per cycle while the input is not
// stalled. After the last cell, if at least three are filled, an iterative depth-first search
// runs over the filled figure: it seeds the stack, then for each of a visited cell's four
// neighbour directions reads the stack top and the neighbour and checks it, and on return
// pops the cell and updates its parent; then it sees the empty stack, and a clearing sweep
// over every memory entry (4096 with the default size) resets the visit marks. The same sweep
// runs once after reset before the first cell is taken. The input is stalled while the search
// and the sweep run; a finished result waits in its output register while the next grid loads,
// and only the last cell of that grid is held back until the result has been taken.
module grid_articulation_point_finder_top
	import gapf_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cell_filled,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] min_cut_code
);
	localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AB = RB + CB;
	localparam int DEPTH = 1 << AB;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int SB = $clog2(CELLS + 1);

	logic [6:0] grid_rows_q, grid_cols_q;
	logic [8:0] rows_u, cols_u;
	always_comb begin
		rows_u = (grid_rows_q == 7'd0) ? 9'd1 :
			(9'(grid_rows_q) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(grid_rows_q);
		cols_u = (grid_cols_q == 7'd0) ? 9'd1 :
			(9'(grid_cols_q) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(grid_cols_q);
	end

	// Cell memories, addressed by {row, column}; the stack memories are addressed by stack position.
	logic           occ_mem [DEPTH];
	logic           seen_mem [DEPTH];
	logic [11:0]    disc_mem [DEPTH];
	logic [11:0]    low_mem [DEPTH];
	logic [AB-1:0]  stk_mem [DEPTH];
	logic [2:0]     dir_mem [DEPTH];

	state_t state_q, state_d;
	logic [8:0]    lrow_q, lcol_q;
	logic [14:0]   filled_q;
	logic [AB-1:0] last_q;
	logic [11:0]   time_q;
	logic [SB-1:0] sp_q;
	logic [1:0]    kids_q;
	logic          found_q;
	logic          search_q;
	logic [AB-1:0] u_q, v_q, p_q;
	logic [11:0]   lowp_q;
	logic [AB:0]   clr_q;
	logic [1:0]    code_q;
	logic          valid_q;

	// Read data registers.
	logic          occ_rd_q, seen_rd_q;
	logic [11:0]   disc_rd_q, low_rd_q;
	logic [AB-1:0] stk_rd_q, stk2_rd_q;
	logic [2:0]    dir_rd_q;

	logic in_acc, out_acc, last_cell;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign last_cell = (lrow_q + 9'd1 == rows_u) && (lcol_q + 9'd1 == cols_u);
	assign in_stall = (state_q != ST_LOAD) || (valid_q && last_cell);
	assign out_valid = valid_q;
	assign min_cut_code = code_q;

	logic [AB-1:0] load_idx;
	assign load_idx = {lrow_q[RB-1:0], lcol_q[CB-1:0]};

	// Neighbour of the stack top in the direction read with it.
	logic [RB-1:0] ur;
	logic [CB-1:0] uc;
	logic          nb_ok;
	logic [AB-1:0] nb_idx;
	always_comb begin
		ur = stk_rd_q[AB-1:CB];
		uc = stk_rd_q[CB-1:0];
		nb_ok = 1'b0;
		nb_idx = stk_rd_q;
		case (dir_rd_q[1:0])
			DIR_DOWN: begin
				nb_ok = (9'(ur) + 9'd1 < rows_u);
				nb_idx = {RB'(ur + 1'b1), uc};
			end
			DIR_UP: begin
				nb_ok = (ur != '0);
				nb_idx = {RB'(ur - 1'b1), uc};
			end
			DIR_LEFT: begin
				nb_ok = (uc != '0);
				nb_idx = {ur, CB'(uc - 1'b1)};
			end
			DIR_RIGHT: begin
				nb_ok = (9'(uc) + 9'd1 < cols_u);
				nb_idx = {ur, CB'(uc + 1'b1)};
			end
			default: nb_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (in_acc && last_cell && filled_q + 15'(cell_filled) >= 15'd3)
				state_d = ST_START;
			ST_START:  state_d = ST_TOP;
			ST_TOP:    state_d = (sp_q == '0) ? ST_CLEAR : ST_NB;
			ST_NB:     state_d = (dir_rd_q[2]) ? ST_POP : ST_NBCHK;
			ST_NBCHK:  state_d = ST_TOP;
			ST_POP:    state_d = ST_POPUPD;
			ST_POPUPD: state_d = ST_TOP;
			ST_CLEAR:  if (clr_q == (AB+1)'(DEPTH - 1)) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
		if (cfg_we && state_q == ST_LOAD) state_d = ST_LOAD;
	end

	// Stack top address helpers.
	logic [SB-1:0] top_a, sec_a;
	assign top_a = sp_q - 1'b1;
	assign sec_a = sp_q - 2'd2;

	// Memory access: each cycle does at most one write per memory.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: if (in_acc) occ_mem[load_idx] <= cell_filled;
			ST_START: begin
				seen_mem[last_q] <= 1'b1;
				disc_mem[last_q] <= '0;
				low_mem[last_q] <= '0;
				stk_mem[0] <= last_q;
				dir_mem[0] <= '0;
			end
			ST_TOP: if (sp_q != '0) begin
				stk_rd_q <= stk_mem[top_a[AB-1:0]];
				dir_rd_q <= dir_mem[top_a[AB-1:0]];
				if (sp_q >= 2) stk2_rd_q <= stk_mem[sec_a[AB-1:0]];
			end
			ST_NB: begin
				if (!dir_rd_q[2]) dir_mem[top_a[AB-1:0]] <= dir_rd_q + 3'd1;
				occ_rd_q <= occ_mem[nb_idx];
				seen_rd_q <= seen_mem[nb_idx];
				disc_rd_q <= disc_mem[nb_idx];
				low_rd_q <= low_mem[stk_rd_q];
			end
			ST_NBCHK: if (nb_ok && occ_rd_q && !(sp_q >= 2 && stk2_rd_q == v_q)) begin
				if (seen_rd_q) begin
					if (disc_rd_q < low_rd_q) low_mem[u_q] <= disc_rd_q;
				end else if (32'(sp_q) < CELLS) begin
					seen_mem[v_q] <= 1'b1;
					disc_mem[v_q] <= time_q;
					low_mem[v_q] <= time_q;
					stk_mem[sp_q[AB-1:0]] <= v_q;
					dir_mem[sp_q[AB-1:0]] <= '0;
				end
			end
			ST_POP: begin
				low_rd_q <= low_mem[u_q];
				disc_rd_q <= disc_mem[p_q];
				stk_rd_q <= p_q;
			end
			ST_POPUPD: if (sp_q != '0 && low_rd_q < lowp_q) low_mem[p_q] <= low_rd_q;
			ST_CLEAR: seen_mem[clr_q[AB-1:0]] <= 1'b0;
			default: ;
		endcase
		if (state_q == ST_POP) lowp_q <= low_mem[p_q];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			grid_rows_q <= 7'd64;
			grid_cols_q <= 7'd64;
			lrow_q <= '0;
			lcol_q <= '0;
			filled_q <= '0;
			last_q <= '0;
			time_q <= '0;
			sp_q <= '0;
			kids_q <= '0;
			found_q <= 1'b0;
			search_q <= 1'b0;
			clr_q <= '0;
			valid_q <= 1'b0;
			code_q <= CODE_IMPOSSIBLE;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_ROWS) grid_rows_q <= cfg_data;
				else grid_cols_q <= cfg_data;
				lrow_q <= '0;
				lcol_q <= '0;
				filled_q <= '0;
				last_q <= '0;
			end
			// A new result is only set while the output register is empty.
			if (out_acc) valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: if (in_acc && !cfg_we) begin
					if (cell_filled) last_q <= load_idx;
					if (last_cell) begin
						lrow_q <= '0;
						lcol_q <= '0;
						filled_q <= '0;
						if (filled_q + 15'(cell_filled) < 15'd3) begin
							code_q <= CODE_IMPOSSIBLE;
							valid_q <= 1'b1;
						end
					end else begin
						if (cell_filled) filled_q <= filled_q + 15'd1;
						if (lcol_q + 9'd1 == cols_u) begin
							lcol_q <= '0;
							lrow_q <= lrow_q + 9'd1;
						end else begin
							lcol_q <= lcol_q + 9'd1;
						end
					end
				end
				ST_START: begin
					time_q <= 12'd1;
					sp_q <= SB'(1);
					kids_q <= '0;
					found_q <= 1'b0;
					search_q <= 1'b1;
				end
				ST_TOP: clr_q <= '0;
				ST_NBCHK: if (nb_ok && occ_rd_q && !(sp_q >= 2 && stk2_rd_q == v_q)
					&& !seen_rd_q && 32'(sp_q) < CELLS) begin
					if (sp_q == SB'(1) && kids_q != 2'd2) kids_q <= kids_q + 2'd1;
					time_q <= time_q + 12'd1;
					sp_q <= sp_q + 1'b1;
				end
				ST_POP: sp_q <= top_a;
				ST_POPUPD: if (sp_q > SB'(1) && low_rd_q >= disc_rd_q) found_q <= 1'b1;
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AB+1)'(DEPTH - 1) && search_q) begin
						code_q <= (found_q || kids_q == 2'd2) ? CODE_CUT : CODE_NONE;
						valid_q <= 1'b1;
						search_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Operand captures used by the neighbour check and the return step.
	always_ff @(posedge clk) begin
		if (state_q == ST_NB) begin
			u_q <= stk_rd_q;
			v_q <= nb_idx;
			p_q <= stk2_rd_q;
		end
	end

`include "grid_articulation_point_finder_top_defines.svh"
	`GAPF_ASSERT(a_hold_result, out_valid && out_stall |=> out_valid && $stable(min_cut_code), "stalled result changed")
	`GAPF_NEVER(a_no_accept_busy, in_acc && state_q != ST_LOAD, "cell taken while searching")
	`GAPF_ASSERT(a_code_legal, out_valid |-> min_cut_code != 2'd3, "illegal result code")
	`GAPF_ASSERT(a_start_stack, state_q == ST_START |=> sp_q == SB'(1), "search did not seed the stack")
endmodule

FILE: sim/grid_articulation_point_finder_top_tb.sv
// Self-checking testbench for the grid articulation point finder.
module grid_articulation_point_finder_top_tb
	import gapf_pkg::*;
;

	localparam int MAXR = 64;
	localparam int MAXC = 64;
	localparam int CELLS = MAXR * MAXC;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD = 400;

	// Keeps its own copy of the grid and predicts the code for each finished grid.
	class cut_code_board;
		bit occ[CELLS];
		bit seen[CELLS];
		logic [11:0] disc[CELLS];
		logic [11:0] low[CELLS];
		int stk[CELLS];
		int dirs[CELLS];
		int sp;
		logic [11:0] tcount;
		logic [6:0] rows_reg;
		logic [6:0] cols_reg;
		int load_pos;
		int filled;
		int last_cell;
		logic [1:0] pending_codes[$];
		int mismatches;
		int codes_seen;
		int code_hist[3];

		function new();
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			load_pos = 0;
			filled = 0;
			last_cell = 0;
			mismatches = 0;
			codes_seen = 0;
		endfunction

		function int rows_used();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAXR) return MAXR;
			return rows_reg;
		endfunction

		function int cols_used();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAXC) return MAXC;
			return cols_reg;
		endfunction

		function void write_reg(logic idx, logic [6:0] val);
			if (idx == REG_ROWS) rows_reg = val;
			else cols_reg = val;
			load_pos = 0;
			filled = 0;
			last_cell = 0;
		endfunction

		function int step_to(int u, int d, int rows, int cols);
			int r;
			int c;
			int v;
			r = u / MAXC;
			c = u % MAXC;
			case (d)
				DIR_DOWN: begin
					if (r + 1 >= rows) return -1;
					r++;
				end
				DIR_UP: begin
					if (r == 0) return -1;
					r--;
				end
				DIR_LEFT: begin
					if (c == 0) return -1;
					c--;
				end
				default: begin
					if (c + 1 >= cols) return -1;
					c++;
				end
			endcase
			v = r * MAXC + c;
			if (!occ[v]) return -1;
			return v;
		endfunction

		function void enter(int v);
			seen[v] = 1;
			disc[v] = tcount;
			low[v] = tcount;
			tcount = tcount + 12'd1;
			stk[sp] = v;
			dirs[sp] = 0;
			sp++;
		endfunction

		function bit has_cut(int root, int rows, int cols);
			int kids;
			bit found;
			int u;
			int k;
			int v;
			int p;
			kids = 0;
			found = 0;
			sp = 0;
			tcount = 0;
			enter(root);
			while (sp > 0) begin
				u = stk[sp - 1];
				k = dirs[sp - 1];
				if (k < 4) begin
					dirs[sp - 1] = k + 1;
					v = step_to(u, k, rows, cols);
					if (v < 0) continue;
					// The edge back to the parent is not a back edge.
					if (sp >= 2 && stk[sp - 2] == v) continue;
					if (seen[v]) begin
						if (disc[v] < low[u]) low[u] = disc[v];
					end else if (sp < CELLS) begin
						if (sp == 1) kids++;
						enter(v);
					end
				end else begin
					sp--;
					if (sp > 0) begin
						p = stk[sp - 1];
						if (low[u] < low[p]) low[p] = low[u];
						if (sp > 1 && low[u] >= disc[p]) found = 1;
					end
				end
			end
			if (kids > 1) found = 1;
			foreach (seen[i]) seen[i] = 0;
			return found;
		endfunction

		function void note_cell(bit b);
			int rows;
			int cols;
			int idx;
			logic [1:0] code;
			rows = rows_used();
			cols = cols_used();
			idx = (load_pos / cols) * MAXC + load_pos % cols;
			if (idx >= CELLS) begin
				load_pos = 0;
				filled = 0;
				last_cell = 0;
				return;
			end
			occ[idx] = b;
			if (b) begin
				filled++;
				last_cell = idx;
			end
			load_pos++;
			if (load_pos < rows * cols) return;
			if (filled < 3) code = CODE_IMPOSSIBLE;
			else code = has_cut(last_cell, rows, cols) ? CODE_CUT : CODE_NONE;
			pending_codes = {pending_codes, code};
			load_pos = 0;
			filled = 0;
			last_cell = 0;
		endfunction

		function void check_code(logic [1:0] got);
			logic [1:0] want;
			if (pending_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: min_cut_code=%0d with nothing pending", got);
				return;
			end
			want = pending_codes.pop_front();
			codes_seen++;
			if (want <= 2) code_hist[want]++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on result %0d: min_cut_code expected %0d, got %0d",
						codes_seen, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [6:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic cell_filled;
	logic out_valid;
	logic out_stall;
	logic [1:0] min_cut_code;

	cut_code_board board;
	int send_idle;
	int recv_idle;
	int hold_req;
	int hold_left;
	int cells_sent;
	int grids_sent;
	int quiet_cycles;
	bit grid_bits[$];

	grid_articulation_point_finder_top #(.MAX_ROWS(MAXR), .MAX_COLS(MAXC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_filled(cell_filled),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.min_cut_code(min_cut_code)
	);

	always #6 clk = ~clk;

	// Result side: check accepted results, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_code(min_cut_code);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_cell(input bit b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_filled <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		board.note_cell(b);
		cells_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val);
	endtask

	task automatic set_shape(input logic [6:0] r, input logic [6:0] c);
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
	endtask

	task automatic send_grid();
		foreach (grid_bits[i]) send_cell(grid_bits[i]);
		grids_sent++;
	endtask

	task automatic send_pattern(input string pat);
		grid_bits.delete();
		foreach (pat[i]) grid_bits = {grid_bits, bit'(pat[i] == "1")};
		send_grid();
	endtask

	// Builds a grid for the current shape: mostly a connected random walk, sometimes
	// random density, sometimes an empty or full grid.
	task automatic build_grid(input int kind);
		int rows;
		int cols;
		int r;
		int c;
		int steps;
		int pick;
		rows = board.rows_used();
		cols = board.cols_used();
		grid_bits.delete();
		for (int i = 0; i < rows * cols; i++)
			grid_bits = {grid_bits,
				bit'(kind == 3 ? 1'b1 : (kind == 1 ? ($urandom_range(1) == 1) : 1'b0))};
		if (kind == 0) begin
			r = $urandom_range(rows - 1);
			c = $urandom_range(cols - 1);
			steps = $urandom_range(rows * cols * 2);
			grid_bits[r * cols + c] = 1'b1;
			for (int s = 0; s < steps; s++) begin
				pick = $urandom_range(3);
				if (pick == 0 && r + 1 < rows) r++;
				else if (pick == 1 && r > 0) r--;
				else if (pick == 2 && c > 0) c--;
				else if (pick == 3 && c + 1 < cols) c++;
				grid_bits[r * cols + c] = 1'b1;
			end
		end
	endtask

	task automatic random_grids(input int cell_goal);
		int goal;
		int kind;
		int pick;
		goal = cells_sent + cell_goal;
		while (cells_sent < goal) begin
			if ($urandom_range(3) == 0)
				set_shape(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)));
			pick = $urandom_range(99);
			kind = pick < 65 ? 0 : (pick < 85 ? 1 : (pick < 92 ? 2 : 3));
			build_grid(kind);
			send_grid();
		end
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = 7'd0;
		in_valid = 1'b0;
		cell_filled = 1'b0;
		out_stall = 1'b0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		cells_sent = 0;
		grids_sent = 0;
		send_idle = 28;
		recv_idle = 45;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a zero register acts as one, tiny grids, cycles and cut vertices.
		set_shape(7'd0, 7'd1);
		send_pattern("1");
		send_pattern("0");
		set_shape(7'd1, 7'd3);
		send_pattern("111");
		send_pattern("101");
		send_pattern("000");
		set_shape(7'd2, 7'd2);
		send_pattern("1111");
		send_pattern("1110");
		set_shape(7'd2, 7'd3);
		// Two separate parts: only the one holding the last filled cell is searched.
		send_pattern("101101");
		// A register write in the middle of a grid drops the partial grid.
		send_cell(1'b1);
		send_cell(1'b0);
		write_reg(REG_COLS, 7'd2);
		send_pattern("1111");

		random_grids(190);
		send_idle = 45;
		recv_idle = 28;
		// Hold off the result side while cells keep coming so the block backs up.
		hold_req = LONG_HOLD;
		random_grids(190);
		send_idle = 0;
		recv_idle = 0;
		random_grids(190);

		// Registers above the maximum act as the maximum: a full-height column and a
		// full-width row.
		set_shape(7'd127, 7'd1);
		build_grid(0);
		send_grid();
		set_shape(7'd1, 7'd127);
		build_grid(3);
		send_grid();

		wait_drained();
		$display("Sent %0d cells in %0d grids; results: %0d impossible, %0d cut, %0d none.",
			cells_sent, grids_sent, board.code_hist[0], board.code_hist[1],
			board.code_hist[2]);
		$display("Shapes up to 6x6 plus a 64-cell column and row, with both sides stalling.");
		if (board.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
